### design/bom_pkg.sv
package bom_pkg;

    localparam int HEAD_BYTES      = 4;
    localparam int SIG_COUNT       = 14;
    localparam int BOM_QUEUE_DEPTH = 2;

    localparam logic [3:0] ENC_NONE = 4'd0;

    // Signature table: length, then bytes (unused tail bytes are zero)
    localparam logic [2:0] SIG_LEN [SIG_COUNT] = '{
        3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd4
    };

    localparam logic [7:0] SIG_SEQ [SIG_COUNT][HEAD_BYTES] = '{
        '{8'hef, 8'hbb, 8'hbf, 8'h00},
        '{8'hfe, 8'hff, 8'h00, 8'h00},
        '{8'hff, 8'hfe, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'hfe, 8'hff},
        '{8'hff, 8'hfe, 8'h00, 8'h00},
        '{8'h2b, 8'h2f, 8'h76, 8'h38},
        '{8'h2b, 8'h2f, 8'h76, 8'h39},
        '{8'h2b, 8'h2f, 8'h76, 8'h2b},
        '{8'h2b, 8'h2f, 8'h76, 8'h2f},
        '{8'hf7, 8'h64, 8'h4c, 8'h00},
        '{8'hdd, 8'h73, 8'h66, 8'h73},
        '{8'h0e, 8'hfe, 8'hff, 8'h00},
        '{8'hfb, 8'hee, 8'h28, 8'h00},
        '{8'h84, 8'h31, 8'h95, 8'h33}
    };

    typedef struct packed {
        logic [3:0] enc;
        logic [2:0] len;
    } bom_match_t;

    // One queued job for the back end: optional status beat, then cnt data
    // beats taken from data[skip] onward.
    typedef struct packed {
        logic                       has_status;
        logic [3:0]                 enc;
        logic [HEAD_BYTES-1:0][7:0] data;
        logic [1:0]                 skip;
        logic [2:0]                 cnt;
        logic                       stream_end;
    } bom_cmd_t;

    // Longest match among signatures that fit in the bytes seen; ties go
    // to the earlier entry.
    function automatic bom_match_t bom_classify(
        input logic [HEAD_BYTES-1:0][7:0] data,
        input logic [2:0]                 seen
    );
        logic [SIG_COUNT-1:0] hit;
        logic [3:0]           cand2;
        logic [3:0]           cand3;
        logic [3:0]           cand4;
        bom_match_t           res;
        hit   = '0;
        cand2 = ENC_NONE;
        cand3 = ENC_NONE;
        cand4 = ENC_NONE;
        for (int t = 0; t < SIG_COUNT; t++)
        begin
            hit[t] = (SIG_LEN[t] <= seen);
            for (int j = 0; j < HEAD_BYTES; j++)
            begin
                if ((3'(j) < SIG_LEN[t]) && (data[j] != SIG_SEQ[t][j]))
                begin
                    hit[t] = 1'b0;
                end
            end
        end
        for (int t = SIG_COUNT - 1; t >= 0; t--)
        begin
            if (hit[t])
            begin
                case (SIG_LEN[t])
                    3'd2:    cand2 = 4'(t + 1);
                    3'd3:    cand3 = 4'(t + 1);
                    3'd4:    cand4 = 4'(t + 1);
                    default: ;
                endcase
            end
        end
        if (cand4 != ENC_NONE)
        begin
            res = '{enc: cand4, len: 3'd4};
        end
        else if (cand3 != ENC_NONE)
        begin
            res = '{enc: cand3, len: 3'd3};
        end
        else if (cand2 != ENC_NONE)
        begin
            res = '{enc: cand2, len: 3'd2};
        end
        else
        begin
            res = '{enc: ENC_NONE, len: 3'd0};
        end
        return res;
    endfunction

endpackage

### design/bom_in_if.sv
interface bom_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

### design/bom_out_if.sv
interface bom_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       carries_byte;
    logic [3:0] encoding;
    logic       is_status;
    logic       run_last;
    logic       stream_done;

    modport source (
        output valid, output out_byte, output carries_byte, output encoding,
        output is_status, output run_last, output stream_done, input ready
    );
    modport sink (
        input valid, input out_byte, input carries_byte, input encoding,
        input is_status, input run_last, input stream_done, output ready
    );
endinterface

### design/bom_front.sv
module bom_front
    import bom_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  logic [7:0] in_byte,
    input  logic     in_end,
    input  logic     cfg_we,
    input  logic     cfg_wdata,
    output logic     push,
    output bom_cmd_t cmd
);

    logic [7:0]                 head_reg [HEAD_BYTES-1];
    logic [1:0]                 head_count_reg;
    logic [1:0]                 head_count_next;
    logic                       decided_reg;
    logic                       decided_next;
    logic                       suppressing_reg;
    logic                       suppressing_next;
    logic                       pass_reg;
    logic [HEAD_BYTES-1:0][7:0] window;
    logic [2:0]                 seen;
    bom_match_t                 match;
    logic                       emit;
    logic                       store;

    // Candidate window: held bytes, current byte at the fill position
    always_comb
    begin
        for (int j = 0; j < HEAD_BYTES - 1; j++)
        begin
            window[j] = (head_count_reg == 2'(j)) ? in_byte : head_reg[j];
        end
        window[HEAD_BYTES-1] = in_byte;
    end

    assign seen  = {1'b0, head_count_reg} + 3'd1;
    assign match = bom_classify(window, seen);
    assign emit  = (match.enc != ENC_NONE) || pass_reg;
    assign store = accept && !decided_reg && !in_end && (head_count_reg != 2'(HEAD_BYTES - 1));

    always_comb
    begin
        push             = 1'b0;
        cmd              = '0;
        head_count_next  = head_count_reg;
        decided_next     = decided_reg;
        suppressing_next = suppressing_reg;
        if (accept)
        begin
            if (!decided_reg)
            begin
                if (store)
                begin
                    head_count_next = head_count_reg + 2'd1;
                end
                else
                begin
                    push            = 1'b1;
                    cmd.has_status  = 1'b1;
                    cmd.enc         = match.enc;
                    cmd.data        = window;
                    cmd.skip        = match.len[1:0];
                    cmd.cnt         = emit ? (seen - match.len) : 3'd0;
                    cmd.stream_end  = in_end;
                    head_count_next = 2'd0;
                    decided_next    = !in_end;
                    suppressing_next = !in_end && !emit;
                end
            end
            else
            begin
                push           = !suppressing_reg;
                cmd.data[0]    = in_byte;
                cmd.cnt        = 3'd1;
                cmd.stream_end = in_end;
                if (in_end)
                begin
                    decided_next     = 1'b0;
                    suppressing_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store)
        begin
            head_reg[head_count_reg] <= in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_count_reg  <= 2'd0;
            decided_reg     <= 1'b0;
            suppressing_reg <= 1'b0;
            pass_reg        <= 1'b1;
        end
        else
        begin
            head_count_reg  <= head_count_next;
            decided_reg     <= decided_next;
            suppressing_reg <= suppressing_next;
            if (cfg_we)
            begin
                pass_reg <= cfg_wdata;
            end
        end
    end

endmodule

### design/bom_cmd_queue.sv
module bom_cmd_queue
    import bom_pkg::*;
#(
    parameter int DEPTH = BOM_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bom_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     head_valid,
    output bom_cmd_t head_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bom_cmd_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;

    assign full       = (count_reg == (PW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/bom_back.sv
module bom_back
    import bom_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    input  bom_cmd_t   cmd,
    output logic       pop,
    input  logic       out_ready,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       carries_byte,
    output logic [3:0] encoding,
    output logic       is_status,
    output logic       run_last,
    output logic       stream_done
);

    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       carries_reg;
    logic [3:0] enc_reg;
    logic       status_reg;
    logic       last_reg;
    logic       done_reg;
    logic       load;
    logic [2:0] total;
    logic [2:0] offset;
    logic [1:0] idx;
    logic       beat_status;
    logic       beat_final;

    // Expand one job into beats; advance when the output register frees up
    assign load        = cmd_valid && (!valid_reg || out_ready);
    assign total       = {2'b00, cmd.has_status} + cmd.cnt;
    assign beat_status = cmd.has_status && (pos_reg == 3'd0);
    assign offset      = pos_reg - {2'b00, cmd.has_status};
    assign idx         = cmd.skip + offset[1:0];
    assign beat_final  = ((pos_reg + 3'd1) == total);
    assign pop         = load && beat_final;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            pos_next   = beat_final ? 3'd0 : pos_reg + 3'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= beat_status ? 8'd0 : cmd.data[idx];
            carries_reg <= !beat_status;
            enc_reg     <= beat_status ? cmd.enc : ENC_NONE;
            status_reg  <= beat_status;
            last_reg    <= beat_final;
            done_reg    <= beat_final && cmd.stream_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_byte     = byte_reg;
    assign carries_byte = carries_reg;
    assign encoding     = enc_reg;
    assign is_status    = status_reg;
    assign run_last     = last_reg;
    assign stream_done  = done_reg;

endmodule

### design/byte_order_mark_stripper_unit.sv
// Byte order mark stripper.
// ingress (sink): one stream byte per beat, stream_end flags the last byte.
// egress (source): result beats. Per stream, the first HEAD_BYTES-1 bytes are
//   held with no output until the fourth byte or the stream end; that beat
//   yields one status beat (encoding, 0 = none) and the window bytes beyond the
//   mark, so up to five egress beats. Later bytes pass one beat each, or are
//   dropped when an unmarked stream is suppressed.
// cfg_we / cfg_wdata: pass_without_mark, sampled when the mark is decided.
// Path: each job is registered in a queue slot, then in the output register.
// Throughput: one ingress beat per cycle in pass-through while the queue has
//   room; a decision beat occupies the back end for one beat per result, and the
//   command queue (QUEUE_DEPTH jobs) absorbs that burst before ingress.ready drops.
// Reset: queue and output register empty, stream state cleared, register
//   set to pass unmarked streams.
// Egress stall: the output register holds its beat; the queue fills and
//   then ingress.ready drops until the receiver takes beats again.
module byte_order_mark_stripper_unit
    import bom_pkg::*;
#(
    parameter int QUEUE_DEPTH = BOM_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    bom_in_if.sink    ingress,
    bom_out_if.source egress,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    logic     accept;
    logic     q_push;
    bom_cmd_t q_push_cmd;
    logic     q_pop;
    logic     q_full;
    logic     q_valid;
    bom_cmd_t q_head;

    // Front: take a beat whenever the queue has room
    assign ingress.ready = !q_full;
    assign accept        = ingress.valid && !q_full;

    bom_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (ingress.data_byte),
        .in_end    (ingress.stream_end),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (q_push),
        .cmd       (q_push_cmd)
    );

    // Decouple classification from beat expansion
    bom_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Back: drive one egress beat per cycle from the queue head while egress is ready
    bom_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (q_head),
        .pop          (q_pop),
        .out_ready    (egress.ready),
        .out_valid    (egress.valid),
        .out_byte     (egress.out_byte),
        .carries_byte (egress.carries_byte),
        .encoding     (egress.encoding),
        .is_status    (egress.is_status),
        .run_last     (egress.run_last),
        .stream_done  (egress.stream_done)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("command pushed into a full queue");

    a_pop_shows_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (egress.valid && egress.run_last))
        else $error("job retired without its final beat on egress");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (egress.valid && egress.stream_done) |-> egress.run_last)
        else $error("stream_done on a beat that is not run_last");

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (egress.valid && egress.is_status) |-> (!egress.carries_byte && egress.out_byte == 8'd0))
        else $error("status beat carries data");
`endif

endmodule
